// ----- hdl/rdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared constants and types for the randomized draw pool: field widths,
// command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package rdp_pkg;

    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int RND_W    = 32;
    localparam int DOUT_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 11;

    // wide enough for any internal count, position or data word
    localparam int EXT_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DRAW    = 2'd1,
        CMD_PEEK    = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOD,
        S_DONE
    } t_state;

endpackage

// ----- hdl/rdp_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_store
// Pool storage: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module rdp_store
    import rdp_pkg::*;
#(
    parameter int  DEPTH  = DEF_CAPACITY,
    parameter int  DATA_W = DEF_DATA_WIDTH,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_a_addr,
    input  logic [AW-1:0]     i_rd_b_addr,
    output logic [DATA_W-1:0] o_rd_a_data,
    output logic [DATA_W-1:0] o_rd_b_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_a_addr];
        r_rd_b <= r_mem[i_rd_b_addr];
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

// ----- hdl/randomized_draw_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// randomized_draw_pool
// Fixed pool of words with enqueue, uniform random draw (hole filled by the
// last entry) and peek by position. One result beat per command.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | i_valid / o_stall  | i_command i_value i_position i_random_word
//  out     | o_valid / i_stall  | o_data_out o_status o_fill_count
//
//  a draw or an accepted peek steps through S_READ, S_MOD and S_DONE before
//  the next accept, any other command skips S_MOD; the store's registered read
//  and the read-then-write of a draw through its single write port set this
//  a waiting result beat does not block the next accept; a result that
//  cannot leave yet holds the sequencer until the output register frees
//  reset clears the fill count, the sequencer and the output valid; the
//  store needs no clearing, every read that is used lies below the fill count
// ----------------------------------------------------------------------------
module randomized_draw_pool
    import rdp_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]    i_position,
    input  logic [RND_W-1:0]    i_random_word,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DOUT_W-1:0]   o_data_out,
    output logic [STATUS_W-1:0] o_status,
    output logic [FILL_W-1:0]   o_fill_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;

    logic [CW-1:0]         r_count;
    logic [1:0]            r_cmd;
    logic [DATA_WIDTH-1:0] r_value;
    logic [POS_W-1:0]      r_pos;
    logic [AW-1:0]         r_k;
    logic [DATA_WIDTH-1:0] r_res_data;
    t_status               r_res_status;

    logic                r_out_valid;
    logic [DOUT_W-1:0]   r_out_data;
    logic [STATUS_W-1:0] r_out_status;
    logic [FILL_W-1:0]   r_out_fill;

    logic                  in_acc;
    logic                  out_free;
    logic [RND_W+CW-1:0]   prod;
    logic [EXT_W-1:0]      val_ext;
    logic [EXT_W-1:0]      res_ext;
    logic [EXT_W-1:0]      cnt_ext;
    logic [EXT_W-1:0]      pos_ext;
    logic [CW-1:0]         last;
    logic                  full;
    logic                  empty;
    logic                  pos_bad;
    logic                  is_enq;
    logic                  is_draw;
    logic                  is_peek;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr_a;
    logic [DATA_WIDTH-1:0] mem_rdata_a;
    logic [DATA_WIDTH-1:0] mem_rdata_b;

    // --- decode ---------------------------------------------------------
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign prod     = i_random_word * r_count;
    assign val_ext  = EXT_W'(i_value);
    assign res_ext  = EXT_W'(r_res_data);
    assign cnt_ext  = EXT_W'(r_count);
    assign pos_ext  = EXT_W'(r_pos);
    assign last     = r_count - 1'b1;
    assign full     = cnt_ext >= EXT_W'(CAPACITY);
    assign empty    = (r_count == '0);
    assign pos_bad  = pos_ext >= cnt_ext;
    assign is_enq   = (r_cmd == CMD_ENQUEUE);
    assign is_draw  = (r_cmd == CMD_DRAW);
    assign is_peek  = (r_cmd == CMD_PEEK);

    // --- sequencer ------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if ((is_draw && !empty) || (is_peek && !pos_bad)) begin
                    n_state = S_MOD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall     = 1'b1;
        mem_we      = 1'b0;
        mem_waddr   = r_k;
        mem_wdata   = mem_rdata_b;
        mem_raddr_a = is_draw ? r_k : pos_ext[AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_READ: begin
                mem_we    = is_enq && !full;
                mem_waddr = r_count[AW-1:0];
                mem_wdata = r_value;
            end
            S_MOD: begin
                // fill the hole with the last entry
                mem_we = is_draw;
            end
            S_DONE: begin
                o_stall = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    rdp_store #(
        .DEPTH  (CAPACITY),
        .DATA_W (DATA_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (mem_we),
        .i_wr_addr   (mem_waddr),
        .i_wr_data   (mem_wdata),
        .i_rd_a_addr (mem_raddr_a),
        .i_rd_b_addr (last[AW-1:0]),
        .o_rd_a_data (mem_rdata_a),
        .o_rd_b_data (mem_rdata_b)
    );

    // --- control registers ----------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ && is_enq && !full) begin
                r_count <= r_count + 1'b1;
            end else if (r_state == S_MOD && is_draw) begin
                r_count <= last;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // --- payload registers ----------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_command;
            r_value <= val_ext[DATA_WIDTH-1:0];
            r_pos   <= i_position;
            // slot = (random * count) >> 32, always below the count
            r_k     <= prod[RND_W +: AW];
        end
        case (r_state)
            S_READ: begin
                r_res_data   <= '0;
                r_res_status <= STS_OK;
                if (is_enq && full) begin
                    r_res_status <= STS_FULL;
                end else if (is_draw && empty) begin
                    r_res_status <= STS_EMPTY;
                end else if (is_peek && pos_bad) begin
                    r_res_status <= STS_RANGE;
                end
            end
            S_MOD: begin
                r_res_data <= mem_rdata_a;
            end
            default: begin
            end
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out_data   <= res_ext[DOUT_W-1:0];
            r_out_status <= r_res_status;
            r_out_fill   <= cnt_ext[FILL_W-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_status     = r_out_status;
    assign o_fill_count = r_out_fill;

endmodule

// ----- tb/randomized_draw_pool_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// randomized_draw_pool_tb
// Drives enqueue, random draw, peek and the unused command code into the pool
// and checks every result beat against an in-bench copy of the pool. A short
// scripted table comes first: empty and out-of-range cases, extreme words and
// draw slots. Random phases follow with sender gaps and receiver stalls. The
// last phase fills the pool to capacity and hovers there so that full
// refusals occur.
// ----------------------------------------------------------------------------
module randomized_draw_pool_tb;
    import rdp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SCRIPT_LEN   = 24;
    localparam int PHASE_ITEMS  = 120;
    localparam int FULL_HOVER   = 60;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic [DOUT_W-1:0] data;
        t_status           status;
        logic [FILL_W-1:0] fill;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic [RND_W-1:0]   rnd;
        logic               typed;
        t_result            res;
    } t_script_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [CMD_W-1:0]    i_command;
    logic [VALUE_W-1:0]  i_value;
    logic [POS_W-1:0]    i_position;
    logic [RND_W-1:0]    i_random_word;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [DOUT_W-1:0]   o_data_out;
    logic [STATUS_W-1:0] o_status;
    logic [FILL_W-1:0]   o_fill_count;

    // in-bench copy of the pool
    logic [DOUT_W-1:0] pool_words [0:DEF_CAPACITY-1];
    logic [FILL_W-1:0] pool_fill;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      stall_pct      = 0;

    // typed rows are plain to read off; the rest go through the predictor
    t_script_row script_rows [SCRIPT_LEN] = '{
        '{CMD_PEEK,    32'h0000_0000, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_RANGE, 11'd0}},
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, STS_EMPTY, 11'd0}},
        '{CMD_UNUSED,  32'h0000_0000, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd0}},
        '{CMD_ENQUEUE, 32'h0000_0000, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd1}},
        '{CMD_ENQUEUE, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd2}},
        '{CMD_PEEK,    32'h0000_0000, 10'd1,    32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, STS_OK,    11'd2}},
        '{CMD_PEEK,    32'h0000_0000, 10'd2,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_RANGE, 11'd2}},
        '{CMD_PEEK,    32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, STS_RANGE, 11'd2}},
        '{CMD_ENQUEUE, 32'h8000_0001, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd3}},
        '{CMD_ENQUEUE, 32'h7FFF_FFFE, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd4}},
        '{CMD_ENQUEUE, 32'hA5A5_5A5A, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd5}},
        // lowest random word takes slot zero
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd4}},
        // highest random word takes the last slot, which moves onto itself
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'hFFFF_FFFF, 1'b1,
          '{32'h7FFF_FFFE, STS_OK,    11'd3}},
        '{CMD_PEEK,    32'h0000_0000, 10'd0,    32'h0000_0000, 1'b0, '0},
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'h8000_0000, 1'b0, '0},
        '{CMD_PEEK,    32'h0000_0000, 10'd1,    32'h0000_0000, 1'b0, '0},
        '{CMD_UNUSED,  32'hDEAD_BEEF, 10'd517,  32'h1357_9BDF, 1'b1,
          '{32'h0000_0000, STS_OK,    11'd2}},
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'h5555_5555, 1'b0, '0},
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'h0000_0000, 1'b0, '0},
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_EMPTY, 11'd0}},
        '{CMD_PEEK,    32'h0000_0000, 10'd0,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, STS_RANGE, 11'd0}},
        '{CMD_ENQUEUE, 32'h1234_5678, 10'd0,    32'h0000_0000, 1'b0, '0},
        '{CMD_PEEK,    32'h0000_0000, 10'd0,    32'h0000_0000, 1'b0, '0},
        '{CMD_DRAW,    32'h0000_0000, 10'd0,    32'hFFFF_FFFF, 1'b0, '0}
    };

    randomized_draw_pool u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_random_word (i_random_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_fill_count  (o_fill_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // updates the pool copy for one accepted command and returns its result
    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] pos,
                                 input logic [RND_W-1:0] rnd,
                                 output t_result res);
        logic [63:0] prod;
        int          slot;
        res = '{data: '0, status: STS_OK, fill: '0};
        if (cmd == CMD_ENQUEUE) begin
            if (int'(pool_fill) >= DEF_CAPACITY) begin
                res.status = STS_FULL;
            end else begin
                pool_words[pool_fill] = value;
                pool_fill = pool_fill + 1'b1;
            end
        end else if (cmd == CMD_DRAW) begin
            if (pool_fill == '0) begin
                res.status = STS_EMPTY;
            end else begin
                prod = 64'(rnd) * 64'(pool_fill);
                slot = int'(prod >> 32);
                res.data = pool_words[slot];
                pool_words[slot] = pool_words[pool_fill - 1'b1];
                pool_fill = pool_fill - 1'b1;
            end
        end else if (cmd == CMD_PEEK) begin
            if (11'(pos) >= pool_fill) begin
                res.status = STS_RANGE;
            end else begin
                res.data = pool_words[pos];
            end
        end
        res.fill = pool_fill;
    endtask

    task automatic drive_beat(input logic [CMD_W-1:0] cmd,
                              input logic [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] pos,
                              input logic [RND_W-1:0] rnd,
                              input logic typed,
                              input t_result typed_res);
        t_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_value       <= value;
        i_position    <= pos;
        i_random_word <= rnd;
        do @(posedge i_clk); while (o_stall);
        apply_command(cmd, value, pos, rnd, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drive_random_beat(input bit fill_mode, input int target);
        int               roll;
        int               enq_w;
        int               drw_w;
        logic [CMD_W-1:0] cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic [RND_W-1:0] rnd;
        if (fill_mode) begin
            enq_w = 88;
            drw_w = 4;
        end else if (int'(pool_fill) < target) begin
            enq_w = 45;
            drw_w = 25;
        end else begin
            enq_w = 15;
            drw_w = 55;
        end
        roll = $urandom_range(0, 99);
        if (roll < enq_w)              cmd = CMD_ENQUEUE;
        else if (roll < enq_w + drw_w) cmd = CMD_DRAW;
        else if (roll < 96)            cmd = CMD_PEEK;
        else                           cmd = CMD_UNUSED;

        roll = $urandom_range(0, 9);
        value = (roll == 0) ? '0 : (roll == 1) ? '1 : VALUE_W'($urandom);
        roll = $urandom_range(0, 9);
        rnd = (roll == 0) ? '0 : (roll == 1) ? '1 : RND_W'($urandom);
        // peeks mostly land on held slots, some on the boundary or anywhere
        roll = $urandom_range(0, 9);
        if (roll < 6 && pool_fill != '0)
            pos = POS_W'($urandom_range(0, int'(pool_fill) - 1));
        else if (roll == 6)
            pos = POS_W'(pool_fill);
        else
            pos = POS_W'($urandom_range(0, 1023));
        drive_beat(cmd, value, pos, rnd, 1'b0, '0);
    endtask

    // sender holds off until every outstanding beat has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t unexpected beat: data %h status %0d fill %0d",
                             $realtime, o_data_out, o_status, o_fill_count);
            end else begin
                want = pending_results.pop_front();
                if (o_data_out !== want.data || o_status !== want.status ||
                    o_fill_count !== want.fill) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t mismatch: data %h/%h status %0d/%0d fill %0d/%0d",
                                 $realtime, want.data, o_data_out, want.status,
                                 o_status, want.fill, o_fill_count);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int target;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= CMD_ENQUEUE;
        i_value       <= '0;
        i_position    <= '0;
        i_random_word <= '0;
        pool_fill = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_rows[i])
            drive_beat(script_rows[i].cmd, script_rows[i].value, script_rows[i].pos,
                       script_rows[i].rnd, script_rows[i].typed, script_rows[i].res);
        drain_results();

        // small pool sizes with gaps and stalls; target zero drains to empty
        target = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 1) ? 0 : (phase == 0) ? 65 : 10;
            stall_pct     = (phase == 0) ? 0 : (phase == 1) ? 65 : 10;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0)
                    target = $urandom_range(0, 24);
                drive_random_beat(1'b0, target);
            end
            drain_results();
        end

        // back to back: fill to capacity, then hover at full
        send_idle_pct = 0;
        stall_pct     = 0;
        while (int'(pool_fill) != DEF_CAPACITY)
            drive_random_beat(1'b1, DEF_CAPACITY);
        for (int n = 0; n < FULL_HOVER; n++)
            drive_random_beat(1'b0, DEF_CAPACITY);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rdp_pkg.sv
hdl/rdp_store.sv
hdl/randomized_draw_pool.sv
tb/randomized_draw_pool_tb.sv
